FILE: src/tcc_pkg.sv
// Shared types, widths and codes for the touch calibration capture block.
// No dependencies; imported by the front end, the executor, the top level and the bench.
package tcc_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF = 15;
   localparam int QUEUE_DEPTH    = 4;

   localparam int ID_W     = 8;
   localparam int COUNT_W  = 4;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 7;
   localparam int PCT_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_POINTS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUAL_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP         = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_PROGRESS = 3'd0;
   localparam logic [STATUS_W-1:0] ST_IDLE_REQ = 3'd1;
   localparam logic [STATUS_W-1:0] ST_POINT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABORT    = 3'd4;

   localparam logic [PCT_W:0] FULL_PERCENT = 8'd100;

   // item kind as decided by the front end
   typedef struct packed {
      logic is_tick;
      logic single;
      logic dual;
   } tcc_class_type;

   localparam int CLASS_W = $bits(tcc_class_type);

endpackage

FILE: src/tcc_fifo.sv
// Small register queue between the front end and the executor.
// Depends on nothing but its parameters.
module tcc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/tcc_front.sv
// Front end: takes request beats, classifies them and packs them for the queue.
// Uses tcc_pkg for the class struct and field widths.
module tcc_front
   import tcc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ITEM_W     = CLASS_W + ID_W + 2 * COORD_BITS
) (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [COUNT_W-1:0]    req_contact_count,
   input  logic [ID_W-1:0]       req_contact_id,
   input  logic [COORD_BITS-1:0] req_contact_x,
   input  logic [COORD_BITS-1:0] req_contact_y,
   output logic                  q_push,
   output logic [ITEM_W-1:0]     q_data,
   input  logic                  q_full
);

   tcc_class_type cls;

   always_comb begin
      cls.is_tick = req_kind;
      cls.single  = (req_contact_count == 4'd1);
      cls.dual    = (req_contact_count == 4'd2);
   end

   // hold the requester off only when the queue has no room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_data    = {cls, req_contact_id, req_contact_x, req_contact_y};

endmodule

FILE: src/tcc_back.sv
// Executor: capture state, progress, session control and the result register.
// Uses tcc_pkg for codes, widths and the class struct.
module tcc_back
   import tcc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ITEM_W     = CLASS_W + ID_W + 2 * COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [ITEM_W-1:0]     q_data,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]    rsp_point_index,
   output logic [PCT_W-1:0]      rsp_progress,
   output logic [COORD_BITS-1:0] rsp_cal_x,
   output logic [COORD_BITS-1:0] rsp_cal_y,
   output logic                  session_done
);

   localparam logic [1:0] MODE_WAIT    = 2'd0;
   localparam logic [1:0] MODE_SETTLE  = 2'd1;
   localparam logic [1:0] MODE_LATCHED = 2'd2;
   localparam logic [INDEX_W-1:0] MAX_PTS = INDEX_W'(MAX_POINTS);

   tcc_class_type         cls;
   logic [ID_W-1:0]       item_id;
   logic [COORD_BITS-1:0] item_x, item_y;

   assign {cls, item_id, item_x, item_y} = q_data;

   // configuration
   logic [6:0] total_ff, dual_lim_ff, step_ff;
   logic [3:0] settle_lim_ff;
   logic [1:0] idle_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= 7'd4;
         settle_lim_ff <= 4'd5;
         dual_lim_ff   <= 7'd100;
         idle_lim_ff   <= 2'd3;
         step_ff       <= 7'd10;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOTAL_POINTS: total_ff      <= csr_wdata;
            CSR_SETTLE:       settle_lim_ff <= csr_wdata[3:0];
            CSR_DUAL_LIMIT:   dual_lim_ff   <= csr_wdata;
            CSR_IDLE_LIMIT:   idle_lim_ff   <= csr_wdata[1:0];
            CSR_STEP:         step_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // capture state
   logic [1:0]            mode_ff, mode_in;
   logic                  done_ff, done_in;
   logic [ID_W-1:0]       tid_ff, tid_in;
   logic [3:0]            settle_ff, settle_in;
   logic [PCT_W-1:0]      pct_ff, pct_in;
   logic [INDEX_W-1:0]    target_ff, target_in;
   logic [COORD_BITS-1:0] avg_x_ff, avg_x_in, avg_y_ff, avg_y_in;
   logic [1:0]            idle_ff, idle_in;
   logic [6:0]            dual_ff, dual_in;
   logic                  seen_ff, seen_in;
   logic                  lws_ff, lws_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   st_ff, st_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;
   logic [PCT_W-1:0]      prog_ff, prog_in;
   logic [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;

   logic                  out_free, res_valid;
   logic [PCT_W:0]        pct_sum;
   logic [INDEX_W-1:0]    target_inc, limit_pts;
   logic [3:0]            settle_inc;
   logic [COORD_BITS:0]   sum_x, sum_y;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign q_pop      = !q_empty && out_free;
   assign pct_sum    = {1'b0, pct_ff} + {1'b0, step_ff};
   assign target_inc = target_ff + 1'b1;
   assign settle_inc = settle_ff + 1'b1;
   assign limit_pts  = (total_ff > MAX_PTS) ? MAX_PTS : total_ff;
   assign sum_x      = {1'b0, avg_x_ff} + {1'b0, item_x};
   assign sum_y      = {1'b0, avg_y_ff} + {1'b0, item_y};

   always_comb begin
      mode_in   = mode_ff;
      done_in   = done_ff;
      tid_in    = tid_ff;
      settle_in = settle_ff;
      pct_in    = pct_ff;
      target_in = target_ff;
      avg_x_in  = avg_x_ff;
      avg_y_in  = avg_y_ff;
      idle_in   = idle_ff;
      dual_in   = dual_ff;
      seen_in   = seen_ff;
      lws_in    = lws_ff;
      res_valid = 1'b0;
      st_in     = ST_PROGRESS;
      idx_in    = target_ff;
      prog_in   = '0;
      cx_in     = '0;
      cy_in     = '0;

      if (q_pop && !done_ff) begin
         if (!cls.is_tick) begin
            seen_in = 1'b1;
            lws_in  = cls.single;
            if (cls.dual) begin
               if (dual_ff >= dual_lim_ff) begin
                  dual_in   = '0;
                  done_in   = 1'b1;
                  res_valid = 1'b1;
                  st_in     = ST_ABORT;
                  prog_in   = pct_ff;
               end else begin
                  dual_in = dual_ff + 1'b1;
               end
            end else begin
               dual_in = '0;
            end

            if (cls.single) begin
               if (mode_ff == MODE_WAIT) begin
                  if (item_id != tid_ff) begin
                     tid_in    = item_id;
                     mode_in   = MODE_SETTLE;
                     settle_in = '0;
                     pct_in    = '0;
                  end
               end else if (item_id != tid_ff) begin
                  // contact changed: drop back, keep the old id
                  mode_in = MODE_WAIT;
                  pct_in  = '0;
               end else if (mode_ff == MODE_SETTLE) begin
                  settle_in = settle_inc;
                  if (settle_inc >= settle_lim_ff) begin
                     avg_x_in  = item_x;
                     avg_y_in  = item_y;
                     mode_in   = MODE_LATCHED;
                     settle_in = '0;
                  end
               end else begin
                  avg_x_in = sum_x[COORD_BITS:1];
                  avg_y_in = sum_y[COORD_BITS:1];
               end
            end
         end else if (!seen_ff) begin
            if (idle_ff >= idle_lim_ff) begin
               pct_in    = '0;
               tid_in    = '0;
               res_valid = 1'b1;
               st_in     = ST_IDLE_REQ;
            end else begin
               idle_in = idle_ff + 1'b1;
            end
         end else begin
            idle_in   = '0;
            seen_in   = 1'b0;
            res_valid = 1'b1;
            prog_in   = pct_ff;
            if (mode_ff == MODE_LATCHED && lws_ff) begin
               if (pct_sum >= FULL_PERCENT) begin
                  pct_in    = '0;
                  prog_in   = '0;
                  target_in = target_inc;
                  mode_in   = MODE_WAIT;
                  cx_in     = avg_x_ff;
                  cy_in     = avg_y_ff;
                  if (target_inc >= limit_pts) begin
                     done_in = 1'b1;
                     st_in   = ST_COMPLETE;
                  end else begin
                     st_in   = ST_POINT;
                  end
               end else begin
                  pct_in  = pct_sum[PCT_W-1:0];
                  prog_in = pct_sum[PCT_W-1:0];
               end
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = q_pop && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT;
         done_ff      <= 1'b0;
         tid_ff       <= '0;
         settle_ff    <= '0;
         pct_ff       <= '0;
         target_ff    <= '0;
         avg_x_ff     <= '0;
         avg_y_ff     <= '0;
         idle_ff      <= '0;
         dual_ff      <= '0;
         seen_ff      <= 1'b0;
         lws_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         done_ff      <= done_in;
         tid_ff       <= tid_in;
         settle_ff    <= settle_in;
         pct_ff       <= pct_in;
         target_ff    <= target_in;
         avg_x_ff     <= avg_x_in;
         avg_y_ff     <= avg_y_in;
         idle_ff      <= idle_in;
         dual_ff      <= dual_in;
         seen_ff      <= seen_in;
         lws_ff       <= lws_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the payload only with a fresh result
   always_ff @(posedge clock) begin
      if (q_pop && res_valid) begin
         st_ff   <= st_in;
         idx_ff  <= idx_in;
         prog_ff <= prog_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = st_ff;
   assign rsp_point_index = idx_ff;
   assign rsp_progress    = prog_ff;
   assign rsp_cal_x       = cx_ff;
   assign rsp_cal_y       = cy_ff;
   assign session_done    = done_ff;

endmodule

FILE: src/touch_calibration_capture_fsm.sv
// Touch calibration capture: top level joining front end, queue and executor.
// An accepted request beat is written into the queue; its response beat is driven
// from the executor's result register. Throughput: one item per cycle while rsp_stall
// is low; a four-entry queue lets request and response sides stall independently.
// Reset: synchronous, active high; clears capture state and queue, loads register defaults.
module touch_calibration_capture_fsm
   import tcc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [COUNT_W-1:0]    req_contact_count,
   input  logic [ID_W-1:0]       req_contact_id,
   input  logic [COORD_BITS-1:0] req_contact_x,
   input  logic [COORD_BITS-1:0] req_contact_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]    rsp_point_index,
   output logic [PCT_W-1:0]      rsp_progress,
   output logic [COORD_BITS-1:0] rsp_cal_x,
   output logic [COORD_BITS-1:0] rsp_cal_y
);

   localparam int ITEM_W = CLASS_W + ID_W + 2 * COORD_BITS;

   logic              q_push, q_full, q_pop, q_empty, session_done;
   logic [ITEM_W-1:0] q_in_data, q_out_data;

   tcc_front #(
      .COORD_BITS(COORD_BITS),
      .ITEM_W    (ITEM_W)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_contact_count(req_contact_count),
      .req_contact_id   (req_contact_id),
      .req_contact_x    (req_contact_x),
      .req_contact_y    (req_contact_y),
      .q_push           (q_push),
      .q_data           (q_in_data),
      .q_full           (q_full)
   );

   tcc_fifo #(
      .WIDTH(ITEM_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_out_data),
      .empty    (q_empty)
   );

   tcc_back #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS),
      .ITEM_W    (ITEM_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_data         (q_out_data),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_point_index(rsp_point_index),
      .rsp_progress   (rsp_progress),
      .rsp_cal_x      (rsp_cal_x),
      .rsp_cal_y      (rsp_cal_y),
      .session_done   (session_done)
   );

   // an ended session never raises a new response
   a_no_rsp_after_end: assert property (@(posedge clock) disable iff (reset)
      (session_done && !rsp_valid) |=> !rsp_valid)
      else $error("response raised after session end");

   // a finished point always reports zero hold progress
   a_done_zero_progress: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_POINT || rsp_status == ST_COMPLETE))
         |-> (rsp_progress == '0))
      else $error("completed point with non-zero progress");

   // progress reports stay below full
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_PROGRESS) |-> (rsp_progress < 7'd100))
      else $error("progress report at or above full");

   // a completed or aborted session leaves the executor ended
   a_complete_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_COMPLETE || rsp_status == ST_ABORT))
         |-> session_done)
      else $error("session end reported while executor still running");

endmodule

FILE: test/testbench.sv
// Self-checking bench for touch_calibration_capture_fsm: frames and ticks with random gaps,
// random response stalls, every result compared against an in-bench model of the capture logic.
// Depends on tcc_pkg and the top level module only.
module testbench
   import tcc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W     = COORD_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic [COUNT_W-1:0] NO_CONTACT     = 4'd0;
   localparam logic [COUNT_W-1:0] SINGLE_CONTACT = 4'd1;
   localparam logic [COUNT_W-1:0] DUAL_CONTACT   = 4'd2;

   typedef enum logic [1:0] {
      CAP_WAIT    = 2'd0,
      CAP_SETTLE  = 2'd1,
      CAP_LATCHED = 2'd2
   } cap_mode_type;

   typedef struct packed {
      logic               kind;
      logic [COUNT_W-1:0] count;
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } touch_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [PCT_W-1:0]    progress;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
   } cal_report_type;

   typedef struct packed {
      logic [6:0] total;
      logic [3:0] settle;
      logic [6:0] dual_limit;
      logic [1:0] idle_limit;
      logic [6:0] step;
   } calib_cfg_type;

   typedef struct packed {
      cap_mode_type       mode;
      logic               done;
      logic [ID_W-1:0]    tracked;
      logic [3:0]         settle_cnt;
      logic [PCT_W-1:0]   pct;
      logic [INDEX_W-1:0] target;
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [1:0]         idle;
      logic [6:0]         duals;
      logic               seen;
      logic               single;
   } calib_state_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [INDEX_W-1:0]    rsp_point_index;
   logic [PCT_W-1:0]      rsp_progress;
   logic [COORD_W-1:0]    rsp_cal_x;
   logic [COORD_W-1:0]    rsp_cal_y;

   touch_item_type  on_bus = '0;
   touch_item_type  pending_items[$];
   cal_report_type  expected_reports[$];
   cal_report_type  bus_report;
   cal_report_type  want;
   calib_cfg_type   cfg;
   calib_state_type live;
   calib_state_type shadow;

   int  mismatches = 0;
   int  items_queued = 0;
   int  cycle_count = 0;
   int  idle_pct = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;
   bit  end_allowed = 1'b0;

   touch_calibration_capture_fsm dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (on_bus.kind),
      .req_contact_count (on_bus.count),
      .req_contact_id    (on_bus.id),
      .req_contact_x     (on_bus.x),
      .req_contact_y     (on_bus.y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_point_index   (rsp_point_index),
      .rsp_progress      (rsp_progress),
      .rsp_cal_x         (rsp_cal_x),
      .rsp_cal_y         (rsp_cal_y)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Advance the capture state by one item; returns 1 when a result beat is due.
   function automatic bit calib_step(inout calib_state_type s, input calib_cfg_type c,
                                     input touch_item_type it, output cal_report_type r);
      logic [PCT_W:0]     pct_sum;
      logic [COORD_W:0]   sum_x;
      logic [COORD_W:0]   sum_y;
      logic [INDEX_W-1:0] limit_pts;
      logic [INDEX_W-1:0] done_idx;
      r = '0;
      if (s.done)
         return 1'b0;
      if (it.kind == KIND_FRAME) begin
         s.seen = 1'b1;
         s.single = (it.count == SINGLE_CONTACT);
         if (it.count == DUAL_CONTACT) begin
            if (s.duals >= c.dual_limit) begin
               s.duals = '0;
               s.done = 1'b1;
               r.status = ST_ABORT;
               r.index = s.target;
               r.progress = s.pct;
               return 1'b1;
            end
            s.duals = s.duals + 7'd1;
         end else begin
            s.duals = '0;
         end
         if (it.count != SINGLE_CONTACT)
            return 1'b0;
         if (s.mode == CAP_WAIT) begin
            if (it.id != s.tracked) begin
               s.tracked = it.id;
               s.mode = CAP_SETTLE;
               s.settle_cnt = '0;
               s.pct = '0;
            end
         end else if (it.id != s.tracked) begin
            // tracked id stays, so the next frame of the new contact arms
            s.mode = CAP_WAIT;
            s.pct = '0;
         end else if (s.mode == CAP_SETTLE) begin
            s.settle_cnt = s.settle_cnt + 4'd1;
            if (s.settle_cnt >= c.settle) begin
               s.ax = it.x;
               s.ay = it.y;
               s.mode = CAP_LATCHED;
               s.settle_cnt = '0;
            end
         end else begin
            sum_x = {1'b0, s.ax} + {1'b0, it.x};
            sum_y = {1'b0, s.ay} + {1'b0, it.y};
            s.ax = sum_x[COORD_W:1];
            s.ay = sum_y[COORD_W:1];
         end
         return 1'b0;
      end
      if (!s.seen) begin
         if (s.idle >= c.idle_limit) begin
            s.pct = '0;
            s.tracked = '0;
            r.status = ST_IDLE_REQ;
            r.index = s.target;
            return 1'b1;
         end
         s.idle = s.idle + 2'd1;
         return 1'b0;
      end
      s.idle = '0;
      s.seen = 1'b0;
      if (s.mode == CAP_LATCHED && s.single) begin
         pct_sum = {1'b0, s.pct} + {1'b0, c.step};
         if (pct_sum >= FULL_PERCENT) begin
            done_idx = s.target;
            s.target = s.target + 7'd1;
            s.mode = CAP_WAIT;
            s.pct = '0;
            limit_pts = (c.total > MAX_POINTS_DEF) ? INDEX_W'(MAX_POINTS_DEF) : c.total;
            if (s.target >= limit_pts) begin
               s.done = 1'b1;
               r.status = ST_COMPLETE;
            end else begin
               r.status = ST_POINT;
            end
            r.index = done_idx;
            r.x = s.ax;
            r.y = s.ay;
            return 1'b1;
         end
         s.pct = pct_sum[PCT_W-1:0];
      end
      r.status = ST_PROGRESS;
      r.index = s.target;
      r.progress = s.pct;
      return 1'b1;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic touch_item_type make_item(logic kind, logic [COUNT_W-1:0] count,
                                                logic [ID_W-1:0] id, logic [COORD_W-1:0] x,
                                                logic [COORD_W-1:0] y);
      touch_item_type it;
      it.kind = kind;
      it.count = count;
      it.id = id;
      it.x = x;
      it.y = y;
      return it;
   endfunction

   function automatic touch_item_type make_frame(logic [COUNT_W-1:0] count,
                                                 logic [ID_W-1:0] id);
      return make_item(KIND_FRAME, count, id, rand_coord(), rand_coord());
   endfunction

   // Ticks carry junk in every other field; the block must ignore it.
   function automatic touch_item_type make_tick();
      return make_item(KIND_TICK, COUNT_W'($urandom), ID_W'($urandom), rand_coord(),
                       rand_coord());
   endfunction

   function automatic touch_item_type noise_item();
      return make_item(1'($urandom), COUNT_W'($urandom), ID_W'($urandom), rand_coord(),
                       rand_coord());
   endfunction

   task automatic note_mismatch(input string what, input longint got, input longint wanted);
      mismatches++;
      $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, wanted);
   endtask

   // Queue one item; outside the closing part, swap anything that would end the
   // session for an empty frame so that the single session lasts the whole run.
   task automatic queue_item(input touch_item_type it);
      calib_state_type trial;
      cal_report_type  rr;
      bit              has;
      trial = shadow;
      has = calib_step(trial, cfg, it, rr);
      if (has && !end_allowed && (rr.status == ST_COMPLETE || rr.status == ST_ABORT)) begin
         it.kind = KIND_FRAME;
         it.count = NO_CONTACT;
         trial = shadow;
         has = calib_step(trial, cfg, it, rr);
      end
      shadow = trial;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic apply_settings(input logic [6:0] total, input logic [3:0] settle,
                                 input logic [6:0] dual, input logic [1:0] idle,
                                 input logic [6:0] step);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TOTAL_POINTS;
      csr_wdata <= total;
      @(posedge clock);
      csr_index <= CSR_SETTLE;
      csr_wdata <= CSR_DATA_W'(settle);
      @(posedge clock);
      csr_index <= CSR_DUAL_LIMIT;
      csr_wdata <= dual;
      @(posedge clock);
      csr_index <= CSR_IDLE_LIMIT;
      csr_wdata <= CSR_DATA_W'(idle);
      @(posedge clock);
      csr_index <= CSR_STEP;
      csr_wdata <= step;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg.total = total;
      cfg.settle = settle;
      cfg.dual_limit = dual;
      cfg.idle_limit = idle;
      cfg.step = step;
   endtask

   // Hold until every beat is through, then give frames time to leave the pipe.
   task automatic settle_down();
      while (pending_items.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      shadow = live;
   endtask

   // One well-formed capture: arm, settle, then frame runs and ticks until the point completes.
   task automatic capture_point();
      logic [ID_W-1:0]    id;
      logic [INDEX_W-1:0] start_target;
      int                 rounds;
      id = ID_W'($urandom);
      start_target = shadow.target;
      rounds = 0;
      queue_item(make_frame(SINGLE_CONTACT, id));
      repeat (int'(cfg.settle) + $urandom_range(2)) queue_item(make_frame(SINGLE_CONTACT, id));
      while (rounds < 40 && shadow.target == start_target && !shadow.done) begin
         repeat ($urandom_range(1, 3)) queue_item(make_frame(SINGLE_CONTACT, id));
         if ($urandom_range(15) == 0)
            queue_item(noise_item());
         queue_item(make_tick());
         rounds++;
      end
   endtask

   task automatic dual_run();
      int len;
      if (cfg.dual_limit <= 7'd20)
         len = $urandom_range(1, int'(cfg.dual_limit) + 1);
      else
         len = $urandom_range(1, 6);
      repeat (len) queue_item(make_frame(DUAL_CONTACT, ID_W'($urandom)));
   endtask

   task automatic run_phase(input logic [6:0] total, input logic [3:0] settle,
                            input logic [6:0] dual, input logic [1:0] idle,
                            input logic [6:0] step, input int gap_pct, input int n);
      int stop;
      int pick;
      apply_settings(total, settle, dual, idle, step);
      idle_pct = gap_pct;
      stop = items_queued + n;
      while (items_queued < stop) begin
         pick = $urandom_range(9);
         if (pick < 6)
            capture_point();
         else if (pick == 6)
            repeat ($urandom_range(1, 5)) queue_item(noise_item());
         else if (pick == 7)
            repeat ($urandom_range(1, 5)) queue_item(make_tick());
         else if (pick == 8)
            dual_run();
         else
            queue_item(make_frame(SINGLE_CONTACT, ID_W'($urandom)));
      end
      settle_down();
   endtask

   // Driver: predict on each accepted beat, then present the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (calib_step(live, cfg, on_bus, bus_report))
               expected_reports.push_back(bus_report);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!calm && pending_items.size() != 0 &&
                         $urandom_range(99) < idle_pct) begin
               gap_left = $urandom_range(12);
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               on_bus <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < idle_pct) begin
         stall_left = $urandom_range(12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            note_mismatch("unexpected beat, status", rsp_status, 0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", rsp_status, want.status);
            if (rsp_point_index !== want.index)
               note_mismatch("point_index", rsp_point_index, want.index);
            if (rsp_progress !== want.progress)
               note_mismatch("progress", rsp_progress, want.progress);
            if (rsp_cal_x !== want.x)
               note_mismatch("cal_x", rsp_cal_x, want.x);
            if (rsp_cal_y !== want.y)
               note_mismatch("cal_y", rsp_cal_y, want.y);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [ID_W-1:0] end_id;
      int              guard;
      live = '0;
      cfg.total = 7'd4;
      cfg.settle = 4'd5;
      cfg.dual_limit = 7'd100;
      cfg.idle_limit = 2'd3;
      cfg.step = 7'd10;
      shadow = live;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part
      apply_settings(7'd127, 4'd1, 7'd2, 2'd0, 7'd50);
      idle_pct = 10;
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'h00, '1, '1)); // id equal to reset id
      queue_item(make_tick());                                          // progress, nothing held
      queue_item(make_tick());                                          // idle request at once
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'hff, '1, '1));
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'hff, '0, '0));
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'hff, '1, '1));
      queue_item(make_tick());
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'hff, 15'd1, 15'd1));
      queue_item(make_tick());                                          // point done
      queue_item(make_item(KIND_FRAME, 4'd10, 8'h55, '1, '0));
      queue_item(make_item(KIND_FRAME, DUAL_CONTACT, 8'h00, '0, '1));
      queue_item(make_item(KIND_FRAME, DUAL_CONTACT, 8'hff, '1, '1));   // run at the limit
      queue_item(make_item(KIND_FRAME, 4'd15, 8'hff, '1, '1));
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'haa, '1, '0));
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'haa, '0, '1));
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'h55, '1, '1)); // other id drops capture
      queue_item(make_tick());
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'h55, '1, '1));
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'h55, '1, '1));
      queue_item(make_item(KIND_TICK, '1, '1, '1, '1));
      queue_item(make_tick());                                          // idle clears tracked id
      queue_item(make_item(KIND_FRAME, SINGLE_CONTACT, 8'h55, '0, '0));
      queue_item(make_item(KIND_FRAME, NO_CONTACT, 8'h00, '0, '0));
      settle_down();

      run_phase(7'd127, 4'd5, 7'd100, 2'd3, 7'd10, 8, 220);
      run_phase(7'd64, 4'd15, 7'd10, 2'd2, 7'd100, 25, 220);
      run_phase(7'd100, 4'd0, 7'd1, 2'd1, 7'd1, 0, 200);
      run_phase(7'd65, 4'd3, 7'd127, 2'd0, 7'd127, 25, 220);
      run_phase(7'd127, 4'd8, 7'd5, 2'd3, 7'd0, 8, 180);
      run_phase(7'd90, 4'd2, 7'd20, 2'd1, 7'd34, 25, 220);
      calm = 1'b1;
      run_phase(7'd127, 4'd1, 7'd3, 2'd2, 7'd25, 0, 120);

      // closing part: end the session one way or the other, then check it stays ended
      end_allowed = 1'b1;
      if ($urandom_range(1) == 0) begin
         apply_settings(7'd127, 4'd1, 7'($urandom_range(3)), 2'd3, 7'd10);
         guard = 0;
         while (!shadow.done && guard < 200) begin
            queue_item(make_frame(DUAL_CONTACT, ID_W'($urandom)));
            guard++;
         end
      end else begin
         apply_settings(($urandom_range(1) == 0) ? 7'd0 : shadow.target + 7'd1, 4'd1, 7'd127,
                        2'd3, 7'd100);
         end_id = shadow.tracked + 8'd1;
         guard = 0;
         while (!(shadow.mode == CAP_LATCHED && shadow.tracked == end_id) && guard < 8) begin
            queue_item(make_frame(SINGLE_CONTACT, end_id));
            guard++;
         end
         queue_item(make_frame(SINGLE_CONTACT, end_id));
         queue_item(make_tick());
      end
      repeat (6) queue_item(noise_item());
      queue_item(make_tick());
      settle_down();

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
